/* hw/rtl/rtis_pkg.sv */
package rtis_pkg;

	localparam int ITEM_W      = 32;
	localparam int RCPT_W      = 32;
	localparam int CNT_W       = 5;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 72;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (RCPT_W + ITEM_W + CNT_W);

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_ITEM_WIDTH = 32;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_INSERTED  = 2'd0;
	localparam status_t ST_REMOVED   = 2'd1;
	localparam status_t ST_NOT_FOUND = 2'd2;
	localparam status_t ST_FULL      = 2'd3;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef struct packed {
		logic capture;
		logic insert;
		logic scan;
		logic hit;
		logic miss;
		logic shift;
		logic dec;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic past_end;
	} dp_stat_t;

endpackage

/* hw/rtl/rtis_dp.sv */
module rtis_dp #(
	parameter int CAPACITY   = rtis_pkg::DEF_CAPACITY,
	parameter int ITEM_WIDTH = rtis_pkg::DEF_ITEM_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rtis_pkg::ITEM_W-1:0]   item_value,
	input  logic [rtis_pkg::RCPT_W-1:0]   receipt_in,
	input  rtis_pkg::dp_cmd_t             cmd,
	output rtis_pkg::dp_stat_t            stat,
	output rtis_pkg::status_t             status,
	output logic [rtis_pkg::RCPT_W-1:0]   receipt_out,
	output logic [rtis_pkg::ITEM_W-1:0]   item_out,
	output logic [rtis_pkg::CNT_W-1:0]    item_count
);
	import rtis_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (ITEM_WIDTH < ITEM_W) ? ITEM_WIDTH : ITEM_W;

	logic [SW-1:0]     item_mem [CAPACITY];
	logic [RCPT_W-1:0] tag_mem  [CAPACITY];

	logic [CW-1:0]     count_q;
	logic [RCPT_W-1:0] next_rcpt_q;
	logic [CW-1:0]     ptr_q;
	logic              rd_issued_s1;
	logic              rd_vld_s1;
	logic [CW-1:0]     rd_idx_s1;
	logic [RCPT_W-1:0] tag_rd_s1;
	logic [SW-1:0]     item_rd_s1;
	logic [SW-1:0]     item_q;
	logic [RCPT_W-1:0] want_q;
	status_t           pend_status_q;
	logic [RCPT_W-1:0] pend_rcpt_q;
	logic [SW-1:0]     pend_item_q;
	status_t           out_status_q;
	logic [RCPT_W-1:0] out_rcpt_q;
	logic [ITEM_W-1:0] out_item_q;
	logic [CNT_W-1:0]  out_cnt_q;

	logic              issue;
	logic              full;
	logic              we;
	logic [IW-1:0]     wa;
	logic [RCPT_W-1:0] wt;
	logic [SW-1:0]     wi;
	logic [CW-1:0]     shift_dst;

	assign issue     = cmd.scan | cmd.shift;
	assign full      = (count_q == CW'(CAPACITY));
	assign shift_dst = rd_idx_s1 - CW'(1);

	// one write port: append on insert, move down one place while compacting
	always_comb begin
		we = 1'b0;
		wa = count_q[IW-1:0];
		wt = next_rcpt_q;
		wi = item_q;
		if (cmd.insert && !full) begin
			we = 1'b1;
		end else if (cmd.shift && rd_vld_s1) begin
			we = 1'b1;
			wa = shift_dst[IW-1:0];
			wt = tag_rd_s1;
			wi = item_rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			tag_mem[wa]  <= wt;
			item_mem[wa] <= wi;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tag_rd_s1  <= tag_mem[ptr_q[IW-1:0]];
			item_rd_s1 <= item_mem[ptr_q[IW-1:0]];
			rd_idx_s1  <= ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			next_rcpt_q  <= RCPT_W'(1);
			ptr_q        <= '0;
			rd_issued_s1 <= 1'b0;
			rd_vld_s1    <= 1'b0;
		end else begin
			rd_issued_s1 <= issue;
			rd_vld_s1    <= issue && (ptr_q < count_q);
			if (cmd.capture) begin
				ptr_q <= '0;
			end else if (cmd.hit) begin
				ptr_q <= rd_idx_s1 + CW'(1);
			end else if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.insert && !full) begin
				count_q     <= count_q + CW'(1);
				next_rcpt_q <= next_rcpt_q + RCPT_W'(1);
			end else if (cmd.dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_value[SW-1:0];
			want_q <= receipt_in;
		end
		if (cmd.insert) begin
			pend_status_q <= full ? ST_FULL : ST_INSERTED;
			pend_rcpt_q   <= full ? '0 : next_rcpt_q;
			pend_item_q   <= '0;
		end else if (cmd.hit) begin
			pend_status_q <= ST_REMOVED;
			pend_rcpt_q   <= '0;
			pend_item_q   <= item_rd_s1;
		end else if (cmd.miss) begin
			pend_status_q <= ST_NOT_FOUND;
			pend_rcpt_q   <= '0;
			pend_item_q   <= '0;
		end
		if (cmd.emit) begin
			out_status_q <= pend_status_q;
			out_rcpt_q   <= pend_rcpt_q;
			out_item_q   <= ITEM_W'(pend_item_q);
			out_cnt_q    <= CNT_W'(count_q);
		end
	end

	assign stat.hit      = rd_vld_s1 && (tag_rd_s1 == want_q);
	assign stat.past_end = rd_issued_s1 && !rd_vld_s1;

	assign status      = out_status_q;
	assign receipt_out = out_rcpt_q;
	assign item_out    = out_item_q;
	assign item_count  = out_cnt_q;

endmodule

/* hw/rtl/rtis_ctrl.sv */
module rtis_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               req_type,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  rtis_pkg::dp_stat_t stat,
	output rtis_pkg::dp_cmd_t  cmd
);
	import rtis_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INS   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = (req_type == REQ_INSERT) ? S_INS : S_SCAN;
				end
			end
			S_INS: begin
				cmd.insert = 1'b1;
				state_d    = S_RESP;
			end
			S_SCAN: begin
				if (stat.hit) begin
					cmd.hit = 1'b1;
					state_d = S_SHIFT;
				end else if (stat.past_end) begin
					cmd.miss = 1'b1;
					state_d  = S_RESP;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_SHIFT: begin
				if (stat.past_end) begin
					cmd.dec = 1'b1;
					state_d = S_RESP;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			S_RESP: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/receipt_tagged_item_store_core.sv */
// channel | dir | tdata (low bit up)                              | tuser
// s       | in  | item_value[31:0], receipt_in[63:32]             | req_type[0]
// m       | out | receipt_out[31:0], item_out[63:32],             | status[1:0]
//         |     | item_count[68:64], zero pad [71:69]             |
// one word in flight: s_tready is high only while the controller is idle
// insert passes through the INS and RESP states from accept to result register
// remove does one table read per cycle, first to scan
// for the receipt, then to move later entries down through the single write port
// a finished result sits in the output register while the next word is taken
// reset: table empty, next receipt 1; table contents are not cleared
module receipt_tagged_item_store_core #(
	parameter int CAPACITY   = rtis_pkg::DEF_CAPACITY,
	parameter int ITEM_WIDTH = rtis_pkg::DEF_ITEM_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rtis_pkg::IN_TDATA_W-1:0]    s_tdata,  // item_value, receipt_in
	input  logic                               s_tuser,  // req_type
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rtis_pkg::OUT_TDATA_W-1:0]   m_tdata,  // receipt_out, item_out, item_count
	output logic [rtis_pkg::STATUS_W-1:0]      m_tuser   // status
);
	import rtis_pkg::*;

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	status_t           status;
	logic [RCPT_W-1:0] receipt_out;
	logic [ITEM_W-1:0] item_out;
	logic [CNT_W-1:0]  item_count;

	rtis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.req_type  (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rtis_dp #(
		.CAPACITY   (CAPACITY),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_value  (s_tdata[ITEM_W-1:0]),
		.receipt_in  (s_tdata[ITEM_W +: RCPT_W]),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.receipt_out (receipt_out),
		.item_out    (item_out),
		.item_count  (item_count)
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, item_count, item_out, receipt_out};
	assign m_tuser = status;

`ifndef SYNTH
	// result register is never overwritten while still unread
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("result overwritten before it was taken");

	// one word at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.insert, cmd.scan, cmd.hit,
			cmd.miss, cmd.shift, cmd.dec, cmd.emit}))
		else $error("conflicting datapath commands");
`endif

endmodule
